// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the ARP responder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/arpc_pkg.sv -----
// Shared constants and types of the ARP responder with address cache.
// No dependencies; used by the table, the top level and the checker.
package arpc_pkg;

   localparam int CACHE_ENTRIES_DEF = 32;

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int TYPE_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 48;
   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 48;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 6;

   localparam logic [TYPE_W-1:0] HW_ETHERNET = 16'h0001;
   localparam logic [TYPE_W-1:0] PROTO_IPV4  = 16'h0800;
   localparam logic [TYPE_W-1:0] OP_REQUEST  = 16'h0001;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'b1;

   typedef enum logic [2:0] {
      OUT_BAD_HW    = 3'd0,
      OUT_BAD_PROTO = 3'd1,
      OUT_NOT_OURS  = 3'd2,
      OUT_NO_REPLY  = 3'd3,
      OUT_REPLY     = 3'd4
   } outcome_type;

   // Commands from the sequencer to the address table.
   typedef struct packed {
      logic rd_en;
      logic ins_en;
   } tbl_cmd_type;

   // Status from the address table back to the sequencer.
   typedef struct packed {
      logic chk_vld;
      logic match;
      logic full;
   } tbl_sts_type;

endpackage

// ----- rtl/arpc_table.sv -----
// Address table of the ARP responder: IP memory, fill count and the shared
// 32-bit compare unit. Depends on arpc_pkg.
module arpc_table #(
   parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
   localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
   localparam int CW = $clog2(CACHE_ENTRIES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  arpc_pkg::tbl_cmd_type     cmd,
   input  logic [AW-1:0]             rd_addr,
   input  logic [arpc_pkg::IP_W-1:0] key_ip,
   output arpc_pkg::tbl_sts_type     sts,
   output logic [CW-1:0]             fill
);

   logic [arpc_pkg::IP_W-1:0] ip_mem [CACHE_ENTRIES];
   logic [arpc_pkg::IP_W-1:0] rdata_ff;
   logic                      chk_vld_ff, chk_vld_in;
   logic [CW-1:0]             fill_ff, fill_in;

   // Entries are filled from the bottom and never freed, so an entry is
   // valid exactly when its index lies below the fill count.
   always_ff @(posedge clock) begin
      if (cmd.ins_en) begin
         ip_mem[fill_ff[AW-1:0]] <= key_ip;
      end
      if (cmd.rd_en) begin
         rdata_ff <= ip_mem[rd_addr];
      end
   end

   always_comb begin
      chk_vld_in = cmd.rd_en;
      fill_in    = cmd.ins_en ? fill_ff + CW'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
         fill_ff    <= '0;
      end else begin
         chk_vld_ff <= chk_vld_in;
         fill_ff    <= fill_in;
      end
   end

   assign sts.chk_vld = chk_vld_ff;
   assign sts.match   = (rdata_ff == key_ip);
   assign sts.full    = (fill_ff == CW'(CACHE_ENTRIES));
   assign fill        = fill_ff;

endmodule

// ----- rtl/arp_cache_responder.sv -----
// Top level of the ARP responder with address cache: handshakes, sequencer
// and result register. Depends on arpc_pkg and arpc_table.
//
// One parsed ARP packet enters per req word and yields one rsp word. A packet
// with a bad hardware or protocol type skips the table and goes from
// acceptance straight to the finish step, which writes the result register.
// Otherwise the sequencer walks the valid entries of the table one per cycle
// through a single memory read port and one 32-bit comparator, stopping at
// the first IP match or, if none of the valid entries matches, once the last
// read has been compared. The result reaches its register at the same clock
// edge at which the block becomes ready again. The block takes no new packet
// while one is being worked on; a finished result waits in its own register
// while the next packet is taken, and a packet whose result is ready stays in
// the finish step for as long as the previous result is still stalled.
// The cache keeps IP addresses and valid entries only: learned MAC addresses
// and own_mac are not returned in any result, so they are not stored.
module arp_cache_responder #(
   parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sender_mac[47:0], sender_ip[79:48], target_ip[111:80]
   input  logic [arpc_pkg::REQ_DATA_W-1:0] req_tdata,
   // hw_type[15:0], proto_type[31:16], opcode[47:32]
   input  logic [arpc_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // reply_dest_mac[47:0], reply_dest_ip[79:48]
   output logic [arpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // outcome[2:0], cache_updated[3], cache_inserted[4], cache_full[5]
   output logic [arpc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CW = $clog2(CACHE_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [arpc_pkg::IP_W-1:0]   own_ip_ff, own_ip_in;
   logic [arpc_pkg::TYPE_W-1:0] hw_ff, proto_ff, op_ff;
   logic [arpc_pkg::MAC_W-1:0]  smac_ff;
   logic [arpc_pkg::IP_W-1:0]   sip_ff, tip_ff;
   logic                        found_ff, found_in;
   logic [CW-1:0]               idx_ff, idx_in;

   logic                        rsp_vld_ff, rsp_vld_in;
   arpc_pkg::outcome_type       outcome_ff, outcome_in;
   logic                        upd_ff, upd_in;
   logic                        ins_ff, ins_in;
   logic                        full_ff, full_in;
   logic [arpc_pkg::MAC_W-1:0]  rmac_ff, rmac_in;
   logic [arpc_pkg::IP_W-1:0]   rip_ff, rip_in;

   arpc_pkg::tbl_cmd_type       tbl_cmd;
   arpc_pkg::tbl_sts_type       tbl_sts;
   logic [CW-1:0]               fill;

   logic req_acc, drop_hw, drop_proto, for_us, out_go, hit;

   arpc_table #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .rd_addr (idx_ff[AW-1:0]),
      .key_ip  (sip_ff),
      .sts     (tbl_sts),
      .fill    (fill)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      drop_hw    = (hw_ff != arpc_pkg::HW_ETHERNET);
      drop_proto = (proto_ff != arpc_pkg::PROTO_IPV4);
      for_us     = (tip_ff == own_ip_ff);
      out_go     = (state_ff == ST_FINISH) && (!rsp_vld_ff || rsp_tready);
      hit        = tbl_sts.chk_vld && tbl_sts.match;
   end

   always_comb begin
      own_ip_in = own_ip_ff;
      if (csr_wen && (csr_index == arpc_pkg::CSR_OWN_IP)) begin
         own_ip_in = csr_wdata[arpc_pkg::IP_W-1:0];
      end
   end

   // Sequencer: the search issues one read per cycle while the compare of
   // the previous read is checked, so a match ends the walk at once.
   always_comb begin
      state_in       = state_ff;
      found_in       = found_ff;
      idx_in         = idx_ff;
      tbl_cmd.rd_en  = 1'b0;
      tbl_cmd.ins_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               found_in = 1'b0;
               idx_in   = '0;
               if ((req_tuser[15:0] != arpc_pkg::HW_ETHERNET) ||
                   (req_tuser[31:16] != arpc_pkg::PROTO_IPV4)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else if (idx_ff < fill) begin
               tbl_cmd.rd_en = 1'b1;
               idx_in        = idx_ff + CW'(1);
            end else if (!tbl_sts.chk_vld) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_go) begin
               state_in = ST_IDLE;
               tbl_cmd.ins_en = !drop_hw && !drop_proto && for_us && !found_ff &&
                                !tbl_sts.full;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      outcome_in = arpc_pkg::OUT_BAD_HW;
      upd_in     = 1'b0;
      ins_in     = 1'b0;
      full_in    = 1'b0;
      rmac_in    = '0;
      rip_in     = '0;
      priority if (drop_hw) begin
         outcome_in = arpc_pkg::OUT_BAD_HW;
      end else if (drop_proto) begin
         outcome_in = arpc_pkg::OUT_BAD_PROTO;
      end else if (!for_us) begin
         outcome_in = arpc_pkg::OUT_NOT_OURS;
         upd_in     = found_ff;
      end else begin
         upd_in  = found_ff;
         ins_in  = !found_ff && !tbl_sts.full;
         full_in = !found_ff && tbl_sts.full;
         if (op_ff == arpc_pkg::OP_REQUEST) begin
            outcome_in = arpc_pkg::OUT_REPLY;
            rmac_in    = smac_ff;
            rip_in     = sip_ff;
         end else begin
            outcome_in = arpc_pkg::OUT_NO_REPLY;
         end
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (out_go) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         own_ip_ff  <= '0;
         found_ff   <= 1'b0;
         idx_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         own_ip_ff  <= own_ip_in;
         found_ff   <= found_in;
         idx_ff     <= idx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         hw_ff    <= req_tuser[15:0];
         proto_ff <= req_tuser[31:16];
         op_ff    <= req_tuser[47:32];
         smac_ff  <= req_tdata[47:0];
         sip_ff   <= req_tdata[79:48];
         tip_ff   <= req_tdata[111:80];
      end
      if (out_go) begin
         outcome_ff <= outcome_in;
         upd_ff     <= upd_in;
         ins_ff     <= ins_in;
         full_ff    <= full_in;
         rmac_ff    <= rmac_in;
         rip_ff     <= rip_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rip_ff, rmac_ff};
   assign rsp_tuser  = {full_ff, ins_ff, upd_ff, outcome_ff};

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checker for the ARP responder and its bind to the top level.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [arpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [arpc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic reply;
   logic dropped;

   assign reply   = (rsp_tuser[2:0] == arpc_pkg::OUT_REPLY);
   assign dropped = (rsp_tuser[2:0] == arpc_pkg::OUT_BAD_HW) ||
                    (rsp_tuser[2:0] == arpc_pkg::OUT_BAD_PROTO);

   // A stalled result word holds its value.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // The block is not ready in the cycle after taking a packet.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "input ready right after accept")

   // Refresh, insertion and full are mutually exclusive.
   `ASSERT_CLK(a_cache_flags, clock, reset, !rsp_tvalid || $onehot0(rsp_tuser[5:3]), "more than one cache flag set")

   // Reply addressing appears only with a reply outcome.
   `ASSERT_CLK(a_reply_fields, clock, reset, !rsp_tvalid || reply || (rsp_tdata == '0), "reply fields set without a reply")

   // A dropped packet reports no cache activity.
   `ASSERT_CLK(a_drop_quiet, clock, reset, !rsp_tvalid || !dropped || (rsp_tuser[5:3] == 3'b000), "dropped packet touched the cache")

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (.*);
